// ----- sv/h2r_pkg.sv -----
`timescale 1ns / 1ps

package h2r_pkg;

    localparam int STAGES = 6;
    localparam int LANES  = 3;

    localparam logic [16:0] Q_ONE        = 17'd65536;
    localparam logic [16:0] Q_HALF       = 17'd32768;
    localparam logic [16:0] Q_THIRD      = 17'd21845;
    localparam logic [16:0] Q_TWO_THIRDS = 17'd43690;

    // ceil(2^32 / 360): hue * 65536 / 360 becomes a multiply and a shift
    localparam logic [23:0] HUE_RECIP = 24'd11930465;

    localparam logic [15:0] RISE_END = 16'd10923;
    localparam logic [15:0] HIGH_END = 16'd32768;
    localparam logic [15:0] FALL_END = 16'd43691;

    localparam logic [16:0] HUE_OFFSET [LANES] = '{Q_THIRD, 17'd0, Q_ONE - Q_THIRD};

    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } seg_t;

endpackage

// ----- sv/hsl_to_rgb.sv -----
`timescale 1ns / 1ps

// HSL to RGB pixel converter.
// Request channel: hue_degrees, saturation, lightness with hsl_valid / hsl_ready.
// Result channel: red, green, blue with rgb_valid / rgb_ready.
// Saturation and lightness are 8-bit fractions (255 = 1.0); hue is in whole
// degrees, values of 360 and above wrap around the color circle.
// Zero saturation returns lightness on all three channels.
// A request passes five work stages and the output register before its result
// is valid. Throughput: one pixel per cycle while rgb_ready is high, set by the
// pipeline: every stage holds one pixel.
// Each stage loads when it is empty or when the stage after it moves, so
// bubbles close up and hsl_ready stays high while any stage is free.
// When the receiver holds rgb_ready low the result holds, stages fill behind it
// and hsl_ready drops once all six are full; nothing is lost or repeated.
// Reset clears all stage valid bits; rgb_valid is low after reset.
module hsl_to_rgb
    import h2r_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       hsl_valid,
    output logic       hsl_ready,
    input  logic [8:0] hue_degrees,
    input  logic [7:0] saturation,
    input  logic [7:0] lightness,
    output logic       rgb_valid,
    input  logic       rgb_ready,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] en;

    // stage 1
    logic [16:0] s1_sq_reg, s1_lq_reg, s1_hq_reg;
    logic        s1_zero_reg;
    logic [7:0]  s1_lit_reg;
    logic [16:0] sq_next, lq_next;
    logic [32:0] hue_prod;

    // stage 2
    logic [18:0] s2_prod_reg;
    logic        s2_low_reg;
    logic [16:0] s2_lq_reg, s2_sq_reg;
    logic        s2_zero_reg;
    logic [7:0]  s2_lit_reg;
    seg_t        s2_seg_reg [LANES];
    logic [15:0] s2_m_reg [LANES];
    logic        low_next;
    logic [17:0] hi_mult;
    logic [34:0] hi_prod;
    seg_t        seg_next [LANES];
    logic [15:0] m_next [LANES];

    // stage 3
    logic [16:0] s3_hi_reg, s3_lq_reg;
    logic        s3_zero_reg;
    logic [7:0]  s3_lit_reg;
    seg_t        s3_seg_reg [LANES];
    logic [15:0] s3_m_reg [LANES];
    logic [18:0] hi_sum, hi_wide;
    logic [16:0] hi_next;

    // stage 4
    logic [16:0] s4_lo_reg, s4_d_reg;
    logic        s4_zero_reg;
    logic [7:0]  s4_lit_reg;
    seg_t        s4_seg_reg [LANES];
    logic [15:0] s4_m_reg [LANES];
    logic [17:0] two_lq, lo_diff;
    logic [16:0] lo_next, d_next;

    // stage 5
    logic [16:0] s5_part_reg [LANES];
    logic [16:0] s5_lo_reg, s5_d_reg;
    logic        s5_zero_reg;
    logic [7:0]  s5_lit_reg;
    seg_t        s5_seg_reg [LANES];
    logic [32:0] part_prod [LANES];

    // output
    logic [7:0]  byte_reg [LANES];
    logic [7:0]  byte_next [LANES];
    logic        gray_reg;

    // ---------------- handshake ----------------
    always_comb
    begin
        en[STAGES-1] = !vld_reg[STAGES-1] || rgb_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign vld_next  = {vld_reg[STAGES-2:0], hsl_valid};
    assign hsl_ready = en[0];
    assign rgb_valid = vld_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    // ---------------- stage 1: scale to Q16 ----------------
    always_comb
    begin
        sq_next  = {1'b0, saturation, saturation} + 17'(saturation == 8'hFF);
        lq_next  = {1'b0, lightness, lightness} + 17'(lightness == 8'hFF);
        hue_prod = 33'(hue_degrees) * 33'(HUE_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_sq_reg   <= sq_next;
            s1_lq_reg   <= lq_next;
            s1_hq_reg   <= hue_prod[32:16];
            s1_zero_reg <= (saturation == 8'd0);
            s1_lit_reg  <= lightness;
        end
    end

    // ---------------- stage 2: level product, channel segments ----------------
    always_comb
    begin
        logic [15:0] v;
        logic [15:0] fall_span;
        low_next = (s1_lq_reg < Q_HALF);
        hi_mult  = low_next ? (18'(Q_ONE) + 18'(s1_sq_reg)) : 18'(s1_sq_reg);
        hi_prod  = 35'(s1_lq_reg) * 35'(hi_mult);
        for (int i = 0; i < LANES; i++)
        begin
            v         = 16'(s1_hq_reg + HUE_OFFSET[i]);
            fall_span = 16'(Q_TWO_THIRDS - 17'(v));
            if (v < RISE_END)
            begin
                seg_next[i] = SEG_RISE;
                m_next[i]   = 16'(19'(v) * 19'd6);
            end
            else if (v < HIGH_END)
            begin
                seg_next[i] = SEG_HIGH;
                m_next[i]   = '0;
            end
            else if (v < FALL_END)
            begin
                seg_next[i] = SEG_FALL;
                m_next[i]   = 16'(19'(fall_span) * 19'd6);
            end
            else
            begin
                seg_next[i] = SEG_LOW;
                m_next[i]   = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_prod_reg <= hi_prod[34:16];
            s2_low_reg  <= low_next;
            s2_lq_reg   <= s1_lq_reg;
            s2_sq_reg   <= s1_sq_reg;
            s2_zero_reg <= s1_zero_reg;
            s2_lit_reg  <= s1_lit_reg;
            for (int i = 0; i < LANES; i++)
            begin
                s2_seg_reg[i] <= seg_next[i];
                s2_m_reg[i]   <= m_next[i];
            end
        end
    end

    // ---------------- stage 3: high level ----------------
    always_comb
    begin
        hi_sum  = 19'(s2_lq_reg) + 19'(s2_sq_reg) - s2_prod_reg;
        hi_wide = s2_low_reg ? s2_prod_reg : hi_sum;
        hi_next = (hi_wide > 19'(Q_ONE)) ? Q_ONE : 17'(hi_wide);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_hi_reg   <= hi_next;
            s3_lq_reg   <= s2_lq_reg;
            s3_zero_reg <= s2_zero_reg;
            s3_lit_reg  <= s2_lit_reg;
            for (int i = 0; i < LANES; i++)
            begin
                s3_seg_reg[i] <= s2_seg_reg[i];
                s3_m_reg[i]   <= s2_m_reg[i];
            end
        end
    end

    // ---------------- stage 4: low level and span ----------------
    always_comb
    begin
        two_lq  = {s3_lq_reg, 1'b0};
        lo_diff = two_lq - 18'(s3_hi_reg);
        if (two_lq <= 18'(s3_hi_reg))
        begin
            lo_next = '0;
        end
        else if (lo_diff > 18'(Q_ONE))
        begin
            lo_next = Q_ONE;
        end
        else
        begin
            lo_next = 17'(lo_diff);
        end
        d_next = (s3_hi_reg > lo_next) ? (s3_hi_reg - lo_next) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_lo_reg   <= lo_next;
            s4_d_reg    <= d_next;
            s4_zero_reg <= s3_zero_reg;
            s4_lit_reg  <= s3_lit_reg;
            for (int i = 0; i < LANES; i++)
            begin
                s4_seg_reg[i] <= s3_seg_reg[i];
                s4_m_reg[i]   <= s3_m_reg[i];
            end
        end
    end

    // ---------------- stage 5: ramp products ----------------
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            part_prod[i] = 33'(s4_d_reg) * 33'(s4_m_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_lo_reg   <= s4_lo_reg;
            s5_d_reg    <= s4_d_reg;
            s5_zero_reg <= s4_zero_reg;
            s5_lit_reg  <= s4_lit_reg;
            for (int i = 0; i < LANES; i++)
            begin
                s5_part_reg[i] <= part_prod[i][32:16];
                s5_seg_reg[i]  <= s4_seg_reg[i];
            end
        end
    end

    // ---------------- stage 6: ramp, scale to byte ----------------
    always_comb
    begin
        logic [17:0] ramp;
        logic [25:0] scaled;
        for (int i = 0; i < LANES; i++)
        begin
            case (s5_seg_reg[i])
                SEG_RISE: ramp = 18'(s5_lo_reg) + 18'(s5_part_reg[i]);
                SEG_HIGH: ramp = 18'(s5_lo_reg) + 18'(s5_d_reg);
                SEG_FALL: ramp = 18'(s5_lo_reg) + 18'(s5_part_reg[i]);
                SEG_LOW:  ramp = 18'(s5_lo_reg);
                default:  ramp = 18'(s5_lo_reg);
            endcase
            scaled = {ramp, 8'b0} - 26'(ramp);
            if (s5_zero_reg)
            begin
                byte_next[i] = s5_lit_reg;
            end
            else if (scaled[25:24] != 2'b00)
            begin
                byte_next[i] = 8'hFF;
            end
            else
            begin
                byte_next[i] = scaled[23:16];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            gray_reg <= s5_zero_reg;
            for (int i = 0; i < LANES; i++)
            begin
                byte_reg[i] <= byte_next[i];
            end
        end
    end

    assign red   = byte_reg[0];
    assign green = byte_reg[1];
    assign blue  = byte_reg[2];

    // ---------------- assertions ----------------
    a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && gray_reg |-> (red == green) && (green == blue))
        else $error("gray pixel with unequal channels");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[STAGES-1] |-> hsl_ready)
        else $error("request stalled with empty output stage");

    a_span_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] && !s4_zero_reg |-> (18'(s4_lo_reg) + 18'(s4_d_reg)) <= 18'(Q_ONE))
        else $error("level span exceeds one");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] && vld_reg[5] && !rgb_ready |=> vld_reg[4] && vld_reg[5])
        else $error("pixel dropped during stall");

endmodule

// ----- dv/hsl_to_rgb_test.sv -----
`timescale 1ns / 1ps

module hsl_to_rgb_test
    import h2r_pkg::*;
();

    localparam longint ONE_Q16        = 65536;
    localparam longint THIRD_Q16      = 21845;
    localparam longint TWO_THIRDS_Q16 = 43690;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_rgb_t;

    logic       clk;
    logic       rst_n;
    logic       hsl_valid;
    logic       hsl_ready;
    logic [8:0] hue_degrees;
    logic [7:0] saturation;
    logic [7:0] lightness;
    logic       rgb_valid;
    logic       rgb_ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    pixel_rgb_t expected_rgb[$];
    int         error_count;
    bit         sender_idle;
    bit         receiver_idle;
    int         stall_request;

    hsl_to_rgb uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .hsl_valid   (hsl_valid),
        .hsl_ready   (hsl_ready),
        .hue_degrees (hue_degrees),
        .saturation  (saturation),
        .lightness   (lightness),
        .rgb_valid   (rgb_valid),
        .rgb_ready   (rgb_ready),
        .red         (red),
        .green       (green),
        .blue        (blue)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic seg_t hue_segment(longint v);
        if (v * 6 < ONE_Q16)
            return SEG_RISE;
        else if (v * 2 < ONE_Q16)
            return SEG_HIGH;
        else if (v * 3 < 2 * ONE_Q16)
            return SEG_FALL;
        return SEG_LOW;
    endfunction

    function automatic logic [7:0] channel_byte(longint lo, longint d, longint v);
        longint level;
        longint scaled;
        case (hue_segment(v))
            SEG_RISE: level = lo + ((d * 6 * v) >> 16);
            SEG_HIGH: level = lo + d;
            SEG_FALL: level = lo + ((d * 6 * (TWO_THIRDS_Q16 - v)) >> 16);
            default:  level = lo;
        endcase
        scaled = (level * 255) >> 16;
        return (scaled > 255) ? 8'd255 : scaled[7:0];
    endfunction

    function automatic pixel_rgb_t hsl_pixel_to_rgb(logic [8:0] h, logic [7:0] s,
                                                   logic [7:0] l);
        pixel_rgb_t px;
        longint     sq;
        longint     lq;
        longint     hq;
        longint     hi;
        longint     lo;
        longint     d;
        if (s == 8'd0)
        begin
            px.red   = l;
            px.green = l;
            px.blue  = l;
            return px;
        end
        sq = (longint'(s) * ONE_Q16) / 255;
        lq = (longint'(l) * ONE_Q16) / 255;
        hq = (longint'(h) * ONE_Q16) / 360;
        if (lq < ONE_Q16 / 2)
            hi = (lq * (ONE_Q16 + sq)) >> 16;
        else
            hi = lq + sq - ((lq * sq) >> 16);
        if (hi < 0)
            hi = 0;
        if (hi > ONE_Q16)
            hi = ONE_Q16;
        lo = 2 * lq - hi;
        if (lo < 0)
            lo = 0;
        if (lo > ONE_Q16)
            lo = ONE_Q16;
        d = (hi > lo) ? hi - lo : 0;
        px.red   = channel_byte(lo, d, (hq + THIRD_Q16) & 16'hFFFF);
        px.green = channel_byte(lo, d, hq & 16'hFFFF);
        px.blue  = channel_byte(lo, d, (hq + ONE_Q16 - THIRD_Q16) & 16'hFFFF);
        return px;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        pixel_rgb_t want;
        if (rst_n)
        begin
            if (hsl_valid && hsl_ready)
                expected_rgb.push_back(hsl_pixel_to_rgb(hue_degrees, saturation, lightness));
            if (rgb_valid && rgb_ready)
            begin
                if (expected_rgb.size() == 0)
                    report_error($sformatf("unexpected result %0d/%0d/%0d", red, green, blue));
                else
                begin
                    want = expected_rgb.pop_front();
                    if (red !== want.red)
                        report_error($sformatf("red %0d, want %0d", red, want.red));
                    if (green !== want.green)
                        report_error($sformatf("green %0d, want %0d", green, want.green));
                    if (blue !== want.blue)
                        report_error($sformatf("blue %0d, want %0d", blue, want.blue));
                end
            end
        end
    end

    initial
    begin
        int n;
        rgb_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_request > 0)
            begin
                n = stall_request;
                stall_request = 0;
                rgb_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else if (receiver_idle && $urandom_range(0, 7) == 0)
            begin
                rgb_ready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge clk);
            end
            else
                rgb_ready <= 1'b1;
        end
    end

    task automatic send_pixel(logic [8:0] h, logic [7:0] s, logic [7:0] l);
        int gap;
        gap = 0;
        if (sender_idle && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 17);
        @(negedge clk);
        if (gap > 0)
        begin
            hsl_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        hsl_valid   <= 1'b1;
        hue_degrees <= h;
        saturation  <= s;
        lightness   <= l;
        do
            @(posedge clk);
        while (!hsl_ready);
    endtask

    task automatic end_requests();
        @(negedge clk);
        hsl_valid <= 1'b0;
    endtask

    task automatic send_random_pixel();
        logic [8:0] h;
        logic [7:0] s;
        logic [7:0] l;
        h = ($urandom_range(0, 6) == 0) ? 9'($urandom_range(361, 511))
                                        : 9'($urandom_range(0, 360));
        case ($urandom_range(0, 9))
            0:       s = 8'd0;
            1:       s = 8'd255;
            default: s = 8'($urandom_range(1, 255));
        endcase
        case ($urandom_range(0, 9))
            0:       l = 8'd0;
            1:       l = 8'd255;
            2:       l = 8'($urandom_range(126, 129));
            default: l = 8'($urandom_range(0, 255));
        endcase
        send_pixel(h, s, l);
    endtask

    task automatic test_gray_levels();
        send_pixel(9'd0, 8'd0, 8'd0);
        send_pixel(9'd200, 8'd0, 8'd128);
        send_pixel(9'd511, 8'd0, 8'd255);
        send_pixel(9'd77, 8'd1, 8'd200);
        end_requests();
    endtask

    task automatic test_primary_hues();
        send_pixel(9'd0, 8'd255, 8'd255);
        send_pixel(9'd0, 8'd255, 8'd0);
        send_pixel(9'd0, 8'd255, 8'd128);
        send_pixel(9'd60, 8'd255, 8'd128);
        send_pixel(9'd120, 8'd255, 8'd128);
        send_pixel(9'd180, 8'd255, 8'd127);
        send_pixel(9'd240, 8'd255, 8'd127);
        send_pixel(9'd300, 8'd255, 8'd128);
        send_pixel(9'd30, 8'd170, 8'd64);
        send_pixel(9'd210, 8'd85, 8'd192);
        end_requests();
    endtask

    task automatic test_hue_wrap();
        send_pixel(9'd359, 8'd255, 8'd128);
        send_pixel(9'd360, 8'd255, 8'd128);
        send_pixel(9'd361, 8'd255, 8'd128);
        send_pixel(9'd480, 8'd200, 8'd100);
        send_pixel(9'd511, 8'd255, 8'd128);
        send_pixel(9'd256, 8'd128, 8'd170);
        end_requests();
    endtask

    task automatic test_random_pixels(int count);
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        repeat (count) send_random_pixel();
        end_requests();
    endtask

    task automatic test_output_stall(int count);
        sender_idle   = 1'b0;
        stall_request = 250;
        repeat (count) send_random_pixel();
        end_requests();
    endtask

    task automatic test_back_to_back(int count);
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        repeat (count) send_random_pixel();
        end_requests();
    endtask

    initial
    begin
        hsl_valid     = 1'b0;
        hue_degrees   = '0;
        saturation    = '0;
        lightness     = '0;
        rst_n         = 1'b0;
        error_count   = 0;
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        stall_request = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_gray_levels();
        test_primary_hues();
        test_hue_wrap();
        test_random_pixels(650);
        test_output_stall(40);
        test_back_to_back(300);

        while (expected_rgb.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/h2r_pkg.sv
sv/hsl_to_rgb.sv
dv/hsl_to_rgb_test.sv
